// ===== rtl/uart_rb_pkg.sv =====
// Shared constants, codes and types for the UART receive/transmit ring buffers.
`default_nettype none

package uart_rb_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 9;
  localparam int unsigned FILL_W = 9;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned IDX_W  = 1;

  localparam int unsigned RX_DEPTH_DEF  = 256;
  localparam int unsigned TX_DEPTH_DEF  = 256;
  localparam int unsigned MAX_BURST_DEF = 16;

  localparam logic [CFG_W-1:0] CAP_RESET = 9'd255;

  // register indexes
  localparam logic [IDX_W-1:0] REG_RX_CAP = 1'b0;
  localparam logic [IDX_W-1:0] REG_TX_CAP = 1'b1;

  // operation codes
  localparam logic [OP_W-1:0] OP_RX_BYTE = 3'd0;
  localparam logic [OP_W-1:0] OP_HOST_RD = 3'd1;
  localparam logic [OP_W-1:0] OP_HOST_WR = 3'd2;
  localparam logic [OP_W-1:0] OP_TX_RDY  = 3'd3;
  localparam logic [OP_W-1:0] OP_TX_DONE = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_RX_DONE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RD_BYTE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NO_DATA  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OVF      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TX_ACC   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TX_FULL  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_LINE     = 3'd6;
  localparam logic [KIND_W-1:0] KIND_IDLE_ACK = 3'd7;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ring_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] level;
    logic [FILL_W-1:0] level_nxt;
    logic              full;
    logic              empty;
  } ring_stat_t;

endpackage

`default_nettype wire

// ===== rtl/uart_rb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module uart_rb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/uart_rb_ring.sv =====
// Byte ring buffer: pointers, fill level and capacity wrap around one RAM.
`default_nettype none

module uart_rb_ring import uart_rb_pkg::*; #(
  parameter int unsigned DEPTH = RX_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CFG_W-1:0]  cap_i,
  input  wire ring_cmd_t         cmd_i,
  input  wire logic [BYTE_W-1:0] wdata_i,
  output logic      [BYTE_W-1:0] rdata_o,
  output ring_stat_t             stat_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;

  logic [CW-1:0]     cap_ext;
  logic [CW-1:0]     cap;
  logic [PW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [PW-1:0]     wp_cur, rp_cur, wp_nxt, rp_nxt;
  logic [CW-1:0]     wp_inc, rp_inc;
  logic [FILL_W-1:0] level_q, level_d;

  // Zero acts as one, anything above the depth acts as the depth.
  always_comb begin
    cap_ext = CW'(cap_i);
    if (cap_ext == '0) begin
      cap = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      cap = CW'(DEPTH);
    end else begin
      cap = cap_ext;
    end
  end

  // A pointer left beyond a shrunken capacity wraps to entry zero before use.
  always_comb begin
    wp_cur = (CW'(wp_q) >= cap) ? '0 : wp_q;
    rp_cur = (CW'(rp_q) >= cap) ? '0 : rp_q;
    wp_inc = CW'(wp_cur) + CW'(1);
    rp_inc = CW'(rp_cur) + CW'(1);
    wp_nxt = (wp_inc >= cap) ? '0 : wp_inc[PW-1:0];
    rp_nxt = (rp_inc >= cap) ? '0 : rp_inc[PW-1:0];
  end

  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    level_d = level_q;
    if (cmd_i.flush) begin
      wp_d    = '0;
      rp_d    = '0;
      level_d = '0;
    end else if (cmd_i.push) begin
      wp_d    = wp_nxt;
      level_d = level_q + FILL_W'(1);
    end else if (cmd_i.pop) begin
      rp_d    = rp_nxt;
      level_d = level_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      level_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      level_q <= level_d;
    end
  end

  uart_rb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push & ~cmd_i.flush),
    .waddr_i (wp_cur),
    .wdata_i (wdata_i),
    .re_i    (cmd_i.pop & ~cmd_i.flush),
    .raddr_i (rp_cur),
    .rdata_o (rdata_o)
  );

  assign stat_o.level     = level_q;
  assign stat_o.level_nxt = level_d;
  assign stat_o.full      = (CW'(level_q) >= cap);
  assign stat_o.empty     = (level_q == '0);

endmodule

`default_nettype wire

// ===== rtl/uart_rx_tx_ring_buffers_unit.sv =====
// Top level: command decode, read burst sequencer and result register for two UART rings.
//
// Every command is taken when start_i is high and busy_o is low, and its result
// appears on the out_* ports in the next cycle, marked by out_valid_o for a single
// cycle; results cannot be held off. All commands but a host read leave busy_o
// low. A host read of n bytes (n = min(read_count, fill level, MAX_BURST))
// streams them out: the receive RAM gives one byte per cycle through its single
// read port, busy_o stays high until the last read is issued and the bytes stream
// out on consecutive cycles, the last one flagged by last_o. Capacities may be written
// on the cfg port only while no command is in flight. No clearing pass runs
// after reset: the ring RAMs are only read at entries written earlier.
`default_nettype none

module uart_rx_tx_ring_buffers_unit import uart_rb_pkg::*; #(
  parameter int unsigned RX_DEPTH  = RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH  = TX_DEPTH_DEF,
  parameter int unsigned MAX_BURST = MAX_BURST_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [OP_W-1:0]   operation_i,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic              overrun_flag_i,
  input  wire logic [CNT_W-1:0]  read_count_i,
  output logic                   out_valid_o,
  output logic [KIND_W-1:0]      kind_o,
  output logic [BYTE_W-1:0]      byte_out_o,
  output logic                   last_o,
  output logic [FILL_W-1:0]      rx_fill_o,
  output logic [FILL_W-1:0]      tx_fill_o,
  output logic                   tx_done_pending_o
);

  localparam int unsigned BW = $clog2(MAX_BURST + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_BURST = 1'b1;

  logic              state_q, state_d;
  logic [BW-1:0]     rem_q, rem_d;
  logic [CFG_W-1:0]  rx_cap_q, tx_cap_q;
  logic              ovf_q, ovf_d;
  logic              tcw_q, tcw_d;
  logic              accept;
  logic [FILL_W-1:0] n_w;
  logic [BW-1:0]     n;

  ring_cmd_t         rx_cmd, tx_cmd;
  ring_stat_t        rx_stat, tx_stat;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;

  logic              vld_d, vld_q;
  logic [KIND_W-1:0] kind_d, kind_q;
  logic              last_d, last_q;
  logic              sel_rx_d, sel_rx_q, sel_tx_d, sel_tx_q;

  assign busy_o = (state_q == ST_BURST);
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_cap_q <= CAP_RESET;
      tx_cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RX_CAP: rx_cap_q <= cfg_data_i;
        REG_TX_CAP: tx_cap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Burst length saturates at the fill level and at MAX_BURST.
  always_comb begin
    n_w = FILL_W'(read_count_i);
    if (n_w > rx_stat.level) begin
      n_w = rx_stat.level;
    end
    if (n_w > FILL_W'(MAX_BURST)) begin
      n_w = FILL_W'(MAX_BURST);
    end
    n = n_w[BW-1:0];
  end

  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    ovf_d    = ovf_q;
    tcw_d    = tcw_q;
    rx_cmd   = '0;
    tx_cmd   = '0;
    vld_d    = 1'b0;
    kind_d   = KIND_IDLE_ACK;
    last_d   = 1'b1;
    sel_rx_d = 1'b0;
    sel_tx_d = 1'b0;
    if (state_q == ST_BURST) begin
      // issue the next read of the burst
      rx_cmd.pop = 1'b1;
      vld_d      = 1'b1;
      kind_d     = KIND_RD_BYTE;
      sel_rx_d   = 1'b1;
      last_d     = (rem_q == BW'(1));
      rem_d      = rem_q - BW'(1);
      if (last_d) begin
        state_d = ST_IDLE;
      end
    end else if (accept) begin
      vld_d = 1'b1;
      case (operation_i)
        OP_RX_BYTE: begin
          kind_d = KIND_RX_DONE;
          if (overrun_flag_i || ovf_q || rx_stat.full) begin
            ovf_d = 1'b1;
          end else begin
            rx_cmd.push = 1'b1;
          end
        end
        OP_HOST_RD: begin
          if (ovf_q) begin
            rx_cmd.flush = 1'b1;
            ovf_d        = 1'b0;
            kind_d       = KIND_OVF;
          end else if (n == '0) begin
            kind_d = KIND_NO_DATA;
          end else begin
            rx_cmd.pop = 1'b1;
            kind_d     = KIND_RD_BYTE;
            sel_rx_d   = 1'b1;
            last_d     = (n == BW'(1));
            rem_d      = n - BW'(1);
            if (!last_d) begin
              state_d = ST_BURST;
            end
          end
        end
        OP_HOST_WR: begin
          if (tx_stat.full) begin
            kind_d = KIND_TX_FULL;
          end else begin
            tx_cmd.push = 1'b1;
            kind_d      = KIND_TX_ACC;
          end
        end
        OP_TX_RDY: begin
          if (!tx_stat.empty) begin
            tx_cmd.pop = 1'b1;
            kind_d     = KIND_LINE;
            sel_tx_d   = 1'b1;
            if (tx_stat.level_nxt == '0) begin
              tcw_d = 1'b1;
            end
          end
        end
        OP_TX_DONE: begin
          tcw_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
      ovf_q   <= 1'b0;
      tcw_q   <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      ovf_q   <= ovf_d;
      tcw_q   <= tcw_d;
      vld_q   <= vld_d;
    end
  end

  // Result payload: snapshot of levels after this step.
  always_ff @(posedge clk_i) begin
    kind_q            <= kind_d;
    last_q            <= last_d;
    sel_rx_q          <= sel_rx_d;
    sel_tx_q          <= sel_tx_d;
    rx_fill_o         <= rx_stat.level_nxt;
    tx_fill_o         <= tx_stat.level_nxt;
    tx_done_pending_o <= tcw_d;
  end

  uart_rb_ring #(
    .DEPTH (RX_DEPTH)
  ) u_rx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cap_i   (rx_cap_q),
    .cmd_i   (rx_cmd),
    .wdata_i (data_byte_i),
    .rdata_o (rx_rdata),
    .stat_o  (rx_stat)
  );

  uart_rb_ring #(
    .DEPTH (TX_DEPTH)
  ) u_tx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cap_i   (tx_cap_q),
    .cmd_i   (tx_cmd),
    .wdata_i (data_byte_i),
    .rdata_o (tx_rdata),
    .stat_o  (tx_stat)
  );

  assign out_valid_o = vld_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;
  assign byte_out_o  = sel_rx_q ? rx_rdata : (sel_tx_q ? tx_rdata : '0);

endmodule

`default_nettype wire

// ===== rtl/uart_rb_checker.sv =====
// Port-level checks on result timing and burst behavior, bound to the top level.
`default_nettype none

module uart_rb_checker import uart_rb_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic              out_valid_o,
  input wire logic [KIND_W-1:0] kind_o,
  input wire logic              last_o,
  input wire logic [FILL_W-1:0] rx_fill_o,
  input wire logic [FILL_W-1:0] tx_fill_o,
  input wire logic              tx_done_pending_o
);

  // every transfer in yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> out_valid_o)
    else $error("no result after accepted command");

  // a burst streams without gaps
  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |=> out_valid_o && kind_o == KIND_RD_BYTE
      && rx_fill_o == $past(rx_fill_o) - FILL_W'(1))
    else $error("read burst broken");

  // hold off new commands while a burst still has bytes to go
  a_busy_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> busy_o)
    else $error("not busy in the middle of a burst");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_OVF |-> rx_fill_o == '0 && last_o)
    else $error("overflow flush left data");

  a_tc_on_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_LINE && tx_fill_o == '0 |-> tx_done_pending_o)
    else $error("transmit ring emptied without completion pending");

endmodule

bind uart_rx_tx_ring_buffers_unit uart_rb_checker u_chk (.*);

`default_nettype wire
